FILE: hw/rtl/tce_pkg.sv
`default_nettype none

package tce_pkg;

  // register slots; anything past the last register selects the scratch word
  localparam int unsigned NumRegs = 11;
  localparam int unsigned SlotW   = 4;

  typedef logic [SlotW-1:0] slot_t;

  localparam slot_t SlotIoa     = 4'd5;
  localparam slot_t SlotIob     = 4'd6;
  localparam slot_t SlotIoc     = 4'd7;
  localparam slot_t SlotIod     = 4'd8;
  localparam slot_t SlotX       = 4'd9;
  localparam slot_t SlotE       = 4'd10;
  localparam slot_t SlotScratch = 4'd11;

  localparam int unsigned PcStep = 4;

  localparam logic [1:0] KindImm = 2'd0;
  localparam logic [1:0] KindReg = 2'd1;

  // configuration register map, indexed by paddr[2]
  localparam logic        CfgMemWordsIdx = 1'b0;
  localparam logic [30:0] MemWordsReset  = 31'd1024;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0,
    OP_ADD = 4'd1,
    OP_SUB = 4'd2,
    OP_DIV = 4'd3,
    OP_MUL = 4'd4,
    OP_JMP = 4'd5,
    OP_CMP = 4'd6,
    OP_JE  = 4'd7,
    OP_JL  = 4'd8,
    OP_JG  = 4'd9,
    OP_JLE = 4'd10,
    OP_JGE = 4'd11,
    OP_MOV = 4'd12,
    OP_IN  = 4'd13,
    OP_OUT = 4'd14
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_OPCODE  = 2'd1,
    ERR_PC      = 2'd2,
    ERR_DIVZERO = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_WR_ERR
  } state_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         dest_index;
    logic [1:0]         operand_kind;
    logic signed [31:0] operand;
    logic signed [31:0] bus_read_data;
  } instr_t;

  typedef struct packed {
    logic [30:0]        next_pc;
    logic               jump_taken;
    logic               halted;
    logic               out_valid;
    logic signed [31:0] out_port;
    logic signed [31:0] out_word_a;
    logic signed [31:0] out_word_b;
    logic signed [31:0] out_word_c;
    logic               in_valid;
    logic signed [31:0] dest_value;
    logic [1:0]         error_raised;
  } result_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic commit;
    logic write_e;
  } ctrl_cmd_t;

  typedef struct packed {
    logic long_op;
    logic long_done;
    logic out_free;
    logic split;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tce_instr_if.sv
`default_nettype none

interface tce_instr_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [3:0]         dest_index;
  logic [1:0]         operand_kind;
  logic signed [31:0] operand;
  logic signed [31:0] bus_read_data;

  modport source (
    output valid, opcode, dest_index, operand_kind, operand, bus_read_data,
    input  ready
  );

  modport sink (
    input  valid, opcode, dest_index, operand_kind, operand, bus_read_data,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/tce_result_if.sv
`default_nettype none

interface tce_result_if;
  logic               valid;
  logic               ready;
  logic [30:0]        next_pc;
  logic               jump_taken;
  logic               halted;
  logic               out_valid;
  logic signed [31:0] out_port;
  logic signed [31:0] out_word_a;
  logic signed [31:0] out_word_b;
  logic signed [31:0] out_word_c;
  logic               in_valid;
  logic signed [31:0] dest_value;
  logic [1:0]         error_raised;

  modport source (
    output valid, next_pc, jump_taken, halted, out_valid, out_port, out_word_a,
           out_word_b, out_word_c, in_valid, dest_value, error_raised,
    input  ready
  );

  modport sink (
    input  valid, next_pc, jump_taken, halted, out_valid, out_port, out_word_a,
           out_word_b, out_word_c, in_valid, dest_value, error_raised,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/tce_ram.sv
`default_nettype none

module tce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tce_muldiv.sv
`default_nettype none

module tce_muldiv #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  is_div_i,
  input  wire logic [DATA_WIDTH-1:0] op_a_i,
  input  wire logic [DATA_WIDTH-1:0] op_b_i,
  output logic                       done_o,
  output logic      [DATA_WIDTH-1:0] result_o
);

  localparam int CntW = $clog2(DATA_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  div_q, div_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [DATA_WIDTH-1:0] a_mag, b_mag, rem_sh;
  logic                  q_bit;

  // shift-add multiply on the raw operands or restoring divide on magnitudes, one bit a cycle
  always_comb begin
    a_mag  = op_a_i[DATA_WIDTH-1] ? -op_a_i : op_a_i;
    b_mag  = op_b_i[DATA_WIDTH-1] ? -op_b_i : op_b_i;
    // remainder stays below the divisor, so its top bit is always clear
    rem_sh = {acc_q[DATA_WIDTH-2:0], a_q[DATA_WIDTH-1]};
    q_bit  = (rem_sh >= b_q);

    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;

    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntW'(DATA_WIDTH);
      div_d  = is_div_i;
      neg_d  = op_a_i[DATA_WIDTH-1] ^ op_b_i[DATA_WIDTH-1];
      acc_d  = '0;
      a_d    = is_div_i ? a_mag : op_a_i;
      b_d    = is_div_i ? b_mag : op_b_i;
    end else if (busy_q) begin
      if (div_q) begin
        acc_d = q_bit ? (rem_sh - b_q) : rem_sh;
        a_d   = {a_q[DATA_WIDTH-2:0], q_bit};
      end else begin
        if (a_q[0]) begin
          acc_d = acc_q + b_q;
        end
        a_d = a_q >> 1;
        b_d = b_q << 1;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? -a_q : a_q) : acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("muldiv started while busy");

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("muldiv busy and done together");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && (cnt_q == CntW'(1))) |=> done_q)
    else $error("muldiv missed done after last step");

endmodule

`default_nettype wire

FILE: hw/rtl/tce_dp.sv
`default_nettype none

module tce_dp import tce_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire instr_t      instr_i,
  input  wire logic [30:0] mem_words_i,
  input  wire ctrl_cmd_t   cmd_i,
  output dp_sts_t          sts_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output result_t          result_o
);

  localparam int CmpW = (DATA_WIDTH > 31) ? DATA_WIDTH : 31;

  // architectural state
  logic [DATA_WIDTH-1:0] pc_q, pc_d;
  logic [DATA_WIDTH-1:0] scratch_q, scratch_d;
  logic [NumRegs-1:0]    vld_q, vld_d;
  logic [DATA_WIDTH-1:0] x_q, x_d, ioa_q, ioa_d, iob_q, iob_d, ioc_q, ioc_d;

  // latched instruction
  logic [3:0]            op_q;
  slot_t                 dst_q, src_q;
  logic [DATA_WIDTH-1:0] bus_q;
  logic                  rv0_q, rv1_q;
  logic [1:0]            err_q;

  logic                  out_vld_q, out_vld_d;
  result_t               out_q;

  // decode of the incoming beat
  logic [DATA_WIDTH-1:0] opnd_in;
  slot_t                 dst_in, src_in, raddr0, raddr1;

  // register file port
  logic                  ram_we;
  slot_t                 ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata, rdata0, rdata1;

  // execute
  logic [DATA_WIDTH-1:0] first, second, p_data, port, wa, wb, wc;
  logic [DATA_WIDTH-1:0] pc_step, pc_raw, pc_new, e_data, dv, unit_res;
  slot_t                 p_addr;
  logic                  p_wen, prim_ram, jump, e_wr, ov, iv, x_neg, x_zero, unit_done;
  err_e                  err;
  result_t               res;

  always_comb begin
    opnd_in = DATA_WIDTH'($signed(instr_i.operand));
    dst_in  = (instr_i.dest_index < slot_t'(NumRegs)) ? instr_i.dest_index : SlotScratch;
    src_in  = SlotScratch;
    if (instr_i.operand_kind == KindReg && opnd_in < DATA_WIDTH'(NumRegs)) begin
      src_in = opnd_in[SlotW-1:0];
    end
    raddr0 = (dst_in == SlotScratch) ? '0 : dst_in;
    raddr1 = (src_in == SlotScratch) ? '0 : src_in;
  end

  always_comb begin
    first  = (dst_q == SlotScratch) ? scratch_q : (rv0_q ? rdata0 : '0);
    second = (src_q == SlotScratch) ? scratch_q : (rv1_q ? rdata1 : '0);
    x_neg  = x_q[DATA_WIDTH-1];
    x_zero = (x_q == '0);

    p_wen  = 1'b0;
    p_addr = dst_q;
    p_data = first;
    jump   = 1'b0;
    err    = ERR_NONE;
    port   = '0;
    wa     = '0;
    wb     = '0;
    wc     = '0;
    ov     = 1'b0;
    iv     = 1'b0;

    case (op_q)
      OP_NOP: begin
      end
      OP_ADD: begin
        p_wen  = 1'b1;
        p_data = first + second;
      end
      OP_SUB: begin
        p_wen  = 1'b1;
        p_data = first - second;
      end
      OP_DIV: begin
        if (second == '0) begin
          err = ERR_DIVZERO;
        end else begin
          p_wen  = 1'b1;
          p_data = unit_res;
        end
      end
      OP_MUL: begin
        p_wen  = 1'b1;
        p_data = unit_res;
      end
      OP_JMP: jump = 1'b1;
      OP_CMP: begin
        p_wen  = 1'b1;
        p_addr = SlotX;
        p_data = first - second;
      end
      OP_JE:  jump = x_zero;
      OP_JL:  jump = x_neg;
      OP_JG:  jump = !x_neg && !x_zero;
      OP_JLE: jump = x_neg || x_zero;
      OP_JGE: jump = !x_neg;
      OP_MOV: begin
        p_wen  = 1'b1;
        p_data = second;
      end
      OP_IN: begin
        port   = first;
        iv     = 1'b1;
        p_wen  = 1'b1;
        p_addr = SlotIod;
        p_data = bus_q;
      end
      OP_OUT: begin
        port = first;
        ov   = 1'b1;
        wa   = ioa_q;
        wb   = iob_q;
        wc   = ioc_q;
      end
      default: err = ERR_OPCODE;
    endcase

    pc_step = pc_q + DATA_WIDTH'(PcStep);
    pc_raw  = jump ? second : pc_step;
    pc_new  = pc_raw;
    // negative counter: error into e and back to zero
    if (pc_raw[DATA_WIDTH-1]) begin
      err    = ERR_PC;
      pc_new = '0;
    end

    e_wr   = (err != ERR_NONE);
    e_data = DATA_WIDTH'(err);

    dv = first;
    if (p_wen && p_addr == dst_q) begin
      dv = p_data;
    end
    if (e_wr && dst_q == SlotE) begin
      dv = e_data;
    end

    prim_ram = p_wen && (p_addr != SlotScratch);

    res.next_pc      = 31'(pc_new);
    res.jump_taken   = jump;
    res.halted       = (CmpW'(pc_new) >= CmpW'(mem_words_i));
    res.out_valid    = ov;
    res.out_port     = 32'(port);
    res.out_word_a   = 32'(wa);
    res.out_word_b   = 32'(wb);
    res.out_word_c   = 32'(wc);
    res.in_valid     = iv;
    res.dest_value   = 32'(dv);
    res.error_raised = err;
  end

  // one write a cycle: the e write follows in its own cycle when both land in the file
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SlotE;
    ram_wdata = e_data;
    if (cmd_i.write_e) begin
      ram_we    = 1'b1;
      ram_wdata = DATA_WIDTH'(err_q);
    end else if (cmd_i.commit) begin
      if (prim_ram && !(e_wr && p_addr == SlotE)) begin
        ram_we    = 1'b1;
        ram_waddr = p_addr;
        ram_wdata = p_data;
      end else if (e_wr) begin
        ram_we = 1'b1;
      end
    end
  end

  always_comb begin
    pc_d      = pc_q;
    scratch_d = scratch_q;
    vld_d     = vld_q;
    x_d       = x_q;
    ioa_d     = ioa_q;
    iob_d     = iob_q;
    ioc_d     = ioc_q;
    out_vld_d = out_vld_q;

    if (cmd_i.accept && instr_i.operand_kind == KindImm) begin
      scratch_d = opnd_in;
    end
    if (cmd_i.commit) begin
      pc_d = pc_new;
      if (p_wen && p_addr == SlotScratch) begin
        scratch_d = p_data;
      end
    end
    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
      if (ram_waddr == SlotX)   x_d   = ram_wdata;
      if (ram_waddr == SlotIoa) ioa_d = ram_wdata;
      if (ram_waddr == SlotIob) iob_d = ram_wdata;
      if (ram_waddr == SlotIoc) ioc_d = ram_wdata;
    end

    if (cmd_i.commit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      scratch_q <= '0;
      vld_q     <= '0;
      x_q       <= '0;
      ioa_q     <= '0;
      iob_q     <= '0;
      ioc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      scratch_q <= scratch_d;
      vld_q     <= vld_d;
      x_q       <= x_d;
      ioa_q     <= ioa_d;
      iob_q     <= iob_d;
      ioc_q     <= ioc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= instr_i.opcode;
      dst_q <= dst_in;
      src_q <= src_in;
      bus_q <= DATA_WIDTH'($signed(instr_i.bus_read_data));
      rv0_q <= vld_q[raddr0];
      rv1_q <= vld_q[raddr1];
    end
    if (cmd_i.commit) begin
      err_q <= err;
      out_q <= res;
    end
  end

  tce_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NumRegs)
  ) u_regfile (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (cmd_i.accept),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  tce_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start),
    .is_div_i (op_q == OP_DIV),
    .op_a_i   (first),
    .op_b_i   (second),
    .done_o   (unit_done),
    .result_o (unit_res)
  );

  assign sts_o.long_op   = (op_q == OP_MUL) || (op_q == OP_DIV && second != '0);
  assign sts_o.long_done = unit_done;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;
  assign sts_o.split     = e_wr && prim_ram && (p_addr != SlotE);

  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tce_ctrl.sv
`default_nettype none

module tce_ctrl import tce_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    instr_valid_i,
  output logic         instr_ready_o,
  input  wire dp_sts_t sts_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (instr_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.long_op) begin
          state_d = ST_WAIT;
        end else if (sts_i.out_free) begin
          state_d = sts_i.split ? ST_WR_ERR : ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (sts_i.long_done && sts_i.out_free) begin
          state_d = sts_i.split ? ST_WR_ERR : ST_IDLE;
        end
      end
      ST_WR_ERR: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    instr_ready_o = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        instr_ready_o = 1'b1;
        cmd_o.accept  = instr_valid_i;
      end
      ST_EXEC: begin
        cmd_o.start  = sts_i.long_op;
        cmd_o.commit = !sts_i.long_op && sts_i.out_free;
      end
      ST_WAIT: begin
        cmd_o.commit = sts_i.long_done && sts_i.out_free;
      end
      ST_WR_ERR: begin
        cmd_o.write_e = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted beat did not move to execute");

  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !sts_i.long_done)
    else $error("unit done still set after start");

  a_split_writes_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && sts_i.split) |=> cmd_o.write_e)
    else $error("pending error write dropped");

endmodule

`default_nettype wire

FILE: hw/rtl/toy_cpu_instruction_execute_top.sv
// sequence: a simple instruction is accepted, executes in the next cycle and its result
//   beat is registered at the end of it, unless an earlier beat not yet taken holds the commit
// flow: a new instruction is accepted only once the last one has committed; an error write
//   to e after a register write takes a step of its own (single write port of the register
//   file); mul and div wait on the one-bit-a-cycle shift-add / restoring divide unit
// reset: asynchronous, active low; registers, scratch and counter read as zero, memory_words
//   returns to 1024 and no result beat is pending
`default_nettype none

module toy_cpu_instruction_execute_top import tce_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,

  tce_instr_if.sink        instr_i,
  tce_result_if.source     result_o
);

  logic [30:0] mem_words_q;
  logic [30:0] mem_words_d;
  logic        cfg_wr;
  logic        cfg_sel;

  instr_t      instr;
  result_t     result;
  ctrl_cmd_t   cmd;
  dp_sts_t     sts;
  logic        out_valid;
  logic        instr_ready;

  // apb write lands on the access cycle; no wait states
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == CfgMemWordsIdx);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? {1'b0, mem_words_q} : '0;

  always_comb begin
    mem_words_d = mem_words_q;
    if (cfg_wr) begin
      mem_words_d = pwdata[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_words_q <= MemWordsReset;
    end else begin
      mem_words_q <= mem_words_d;
    end
  end

  // gather the input beat
  assign instr.opcode        = instr_i.opcode;
  assign instr.dest_index    = instr_i.dest_index;
  assign instr.operand_kind  = instr_i.operand_kind;
  assign instr.operand       = instr_i.operand;
  assign instr.bus_read_data = instr_i.bus_read_data;
  assign instr_i.ready       = instr_ready;

  // sequencer: accept, execute, wait on the unit, trailing error write
  tce_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_valid_i (instr_i.valid),
    .instr_ready_o (instr_ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // register file, counter, alu, mul/div unit and the result register
  tce_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .instr_i     (instr),
    .mem_words_i (mem_words_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  // result beat; its register lets the next instruction in while this one waits
  assign result_o.valid        = out_valid;
  assign result_o.next_pc      = result.next_pc;
  assign result_o.jump_taken   = result.jump_taken;
  assign result_o.halted       = result.halted;
  assign result_o.out_valid    = result.out_valid;
  assign result_o.out_port     = result.out_port;
  assign result_o.out_word_a   = result.out_word_a;
  assign result_o.out_word_b   = result.out_word_b;
  assign result_o.out_word_c   = result.out_word_c;
  assign result_o.in_valid     = result.in_valid;
  assign result_o.dest_value   = result.dest_value;
  assign result_o.error_raised = result.error_raised;

endmodule

`default_nettype wire

FILE: verif/toy_cpu_instruction_execute_top_tb.sv
`timescale 1ns / 1ps

module toy_cpu_instruction_execute_top_tb;
  import tce_pkg::*;

  // register slots that the package leaves unnamed
  localparam slot_t SlotNop  = 4'd0;
  localparam slot_t SlotA    = 4'd1;
  localparam slot_t SlotB    = 4'd2;
  localparam slot_t SlotC    = 4'd3;
  localparam slot_t SlotD    = 4'd4;
  localparam slot_t SlotHigh = 4'd15;  // top index, aliases the scratch word

  localparam logic [3:0] OpUnknown   = 4'd15;
  localparam logic [1:0] KindKeepLo  = 2'd2;  // both of these reuse scratch as it is
  localparam logic [1:0] KindKeepHi  = 2'd3;

  localparam logic [2:0] MemWordsAddr = {CfgMemWordsIdx, 2'b00};

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 265;
  localparam int unsigned CfgSettle     = 4;   // cycles of quiet before a register write
  localparam int unsigned EndSettle     = 40;  // covers the multi-cycle mul/div unit

  // ---------------------------------------------------------------------------
  // execute-stage tracker: mirrors the architectural state and queues the
  // result beat that every accepted instruction must produce
  // ---------------------------------------------------------------------------
  class tce_exec_tracker;
    logic signed [31:0] slots [12];  // eleven registers, then the scratch word
    logic [31:0]        pc;
    logic [30:0]        mem_words;
    result_t            expected_beats [$];
    int unsigned        mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      pc         = '0;
      mem_words  = MemWordsReset;
      mismatches = 0;
    endfunction

    function void set_mem_words(logic [30:0] v);
      mem_words = v;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void note_instr(instr_t t);
      slot_t              dst;
      slot_t              src;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] xv;
      longint             num;
      longint             den;
      longint             quo;
      logic               jump;
      err_e               err;
      result_t            r;

      dst  = (t.dest_index < NumRegs) ? t.dest_index : SlotScratch;
      jump = 1'b0;
      err  = ERR_NONE;
      r    = '0;

      // operand fetch; an immediate lands in scratch first so dest can see it too
      if (t.operand_kind == KindImm) begin
        slots[SlotScratch] = t.operand;
        src = SlotScratch;
      end else if (t.operand_kind == KindReg) begin
        // negative indexes compare as huge unsigned values and fall to scratch
        src = ($unsigned(t.operand) < NumRegs) ? slot_t'(t.operand[3:0]) : SlotScratch;
      end else begin
        src = SlotScratch;
      end
      first  = slots[dst];
      second = slots[src];
      xv     = slots[SlotX];

      case (t.opcode)
        OP_NOP: ;
        OP_ADD: slots[dst] = first + second;
        OP_SUB: slots[dst] = first - second;
        OP_DIV: begin
          if (second == 0) begin
            err = ERR_DIVZERO;
          end else begin
            // 64-bit quotient truncates toward zero; min / -1 wraps on the cut
            num = first;
            den = second;
            quo = num / den;
            slots[dst] = quo[31:0];
          end
        end
        OP_MUL: slots[dst] = first * second;
        OP_JMP: jump = 1'b1;
        OP_CMP: slots[SlotX] = first - second;
        OP_JE:  jump = (xv == 0);
        OP_JL:  jump = xv[31];
        OP_JG:  jump = !xv[31] && (xv != 0);
        OP_JLE: jump = xv[31] || (xv == 0);
        OP_JGE: jump = !xv[31];
        OP_MOV: slots[dst] = second;
        OP_IN: begin
          r.out_port      = first;  // port is read before the bus value lands
          r.in_valid      = 1'b1;
          slots[SlotIod]  = t.bus_read_data;
        end
        OP_OUT: begin
          r.out_port   = first;
          r.out_valid  = 1'b1;
          r.out_word_a = slots[SlotIoa];
          r.out_word_b = slots[SlotIob];
          r.out_word_c = slots[SlotIoc];
        end
        default: err = ERR_OPCODE;
      endcase

      if (jump) pc = second;
      else      pc = pc + PcStep;

      if (err != ERR_NONE) slots[SlotE] = 32'(err);
      // a negative counter overrides any other error and snaps back to zero
      if (pc[31]) begin
        err          = ERR_PC;
        slots[SlotE] = 32'(ERR_PC);
        pc           = '0;
      end

      r.next_pc      = pc[30:0];
      r.jump_taken   = jump;
      r.halted       = (pc[30:0] >= mem_words);
      r.dest_value   = slots[dst];
      r.error_raised = err;
      expected_beats.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) note_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        note_mismatch("result beat with no instruction outstanding");
        return;
      end
      want = expected_beats.pop_front();
      cmp_field("next_pc",      32'(want.next_pc),      32'(got.next_pc));
      cmp_field("jump_taken",   32'(want.jump_taken),   32'(got.jump_taken));
      cmp_field("halted",       32'(want.halted),       32'(got.halted));
      cmp_field("out_valid",    32'(want.out_valid),    32'(got.out_valid));
      cmp_field("out_port",     want.out_port,          got.out_port);
      cmp_field("out_word_a",   want.out_word_a,        got.out_word_a);
      cmp_field("out_word_b",   want.out_word_b,        got.out_word_b);
      cmp_field("out_word_c",   want.out_word_c,        got.out_word_c);
      cmp_field("in_valid",     32'(want.in_valid),     32'(got.in_valid));
      cmp_field("dest_value",   want.dest_value,        got.dest_value);
      cmp_field("error_raised", 32'(want.error_raised), 32'(got.error_raised));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and the bench-side signals
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit calm = 1'b0;  // set for a stretch where neither side idles

  tce_exec_tracker tracker;

  tce_instr_if  instr_bus ();
  tce_result_if result_bus ();

  always #6 clk_i = ~clk_i;

  toy_cpu_instruction_execute_top #(
    .DATA_WIDTH (32)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .instr_i  (instr_bus),
    .result_o (result_bus)
  );

  // ---------------------------------------------------------------------------
  // monitors: both sample the pre-edge values of the handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : instr_mon
    instr_t item;
    if (rst_ni && instr_bus.valid && instr_bus.ready) begin
      item.opcode        = instr_bus.opcode;
      item.dest_index    = instr_bus.dest_index;
      item.operand_kind  = instr_bus.operand_kind;
      item.operand       = instr_bus.operand;
      item.bus_read_data = instr_bus.bus_read_data;
      tracker.note_instr(item);
    end
  end

  always @(posedge clk_i) begin : beat_mon
    result_t beat;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      beat.next_pc      = result_bus.next_pc;
      beat.jump_taken   = result_bus.jump_taken;
      beat.halted       = result_bus.halted;
      beat.out_valid    = result_bus.out_valid;
      beat.out_port     = result_bus.out_port;
      beat.out_word_a   = result_bus.out_word_a;
      beat.out_word_b   = result_bus.out_word_b;
      beat.out_word_c   = result_bus.out_word_c;
      beat.in_valid     = result_bus.in_valid;
      beat.dest_value   = result_bus.dest_value;
      beat.error_raised = result_bus.error_raised;
      tracker.check_beat(beat);
    end
  end

  // receiver back-pressure, ready low with a chance of roughly 23 in a hundred outside the calm stretch
  always @(posedge clk_i) begin
    result_bus.ready <= !rst_ni ? 1'b0 : (calm ? 1'b1 : ($urandom_range(99) >= 23));
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  function automatic instr_t mk(logic [3:0] op, slot_t dst, logic [1:0] kind,
                                logic signed [31:0] opnd, logic signed [31:0] bus);
    instr_t t;
    t.opcode        = op;
    t.dest_index    = dst;
    t.operand_kind  = kind;
    t.operand       = opnd;
    t.bus_read_data = bus;
    return t;
  endfunction

  // mostly well-formed instructions, with jump targets around the memory size
  function automatic instr_t rand_instr();
    instr_t             t;
    int unsigned        r;
    logic signed [31:0] corner [6] = '{32'sh0, -32'sh1, 32'sh1, 32'sh7FFFFFFF,
                                       32'sh80000000, 32'sh7FFFFFFC};
    r = $urandom_range(99);
    t.opcode = (r < 3) ? OpUnknown : 4'($urandom_range(14));
    r = $urandom_range(99);
    t.dest_index = (r < 80) ? 4'($urandom_range(10)) : 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 40)      t.operand_kind = KindImm;
    else if (r < 75) t.operand_kind = KindReg;
    else             t.operand_kind = 2'($urandom_range(KindKeepLo, KindKeepHi));
    r = $urandom_range(99);
    if (t.operand_kind == KindReg)
      t.operand = (r < 85) ? 32'($urandom_range(10)) : $urandom();
    else if (t.opcode inside {OP_JMP, OP_JE, OP_JL, OP_JG, OP_JLE, OP_JGE} && r < 80)
      t.operand = 32'($urandom_range(400)) << 2;
    else if (r < 30)
      t.operand = $urandom();
    else if (r < 60)
      t.operand = $signed(32'($urandom_range(64))) - 32;
    else if (r < 75)
      t.operand = corner[$urandom_range(5)];
    else
      t.operand = 32'($urandom_range(2047));
    t.bus_read_data = $urandom();
    return t;
  endfunction

  // one instruction beat; valid stays high after acceptance so that
  // back-to-back beats never toggle it within one step
  task automatic send_instr(instr_t t);
    if (!calm && $urandom_range(99) < 12) begin
      instr_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    instr_bus.valid         <= 1'b1;
    instr_bus.opcode        <= t.opcode;
    instr_bus.dest_index    <= t.dest_index;
    instr_bus.operand_kind  <= t.operand_kind;
    instr_bus.operand       <= t.operand;
    instr_bus.bus_read_data <= t.bus_read_data;
    do @(posedge clk_i); while (!instr_bus.ready);
  endtask

  // stop sending and wait until every outstanding result beat is back
  task automatic drain(int unsigned settle);
    instr_bus.valid <= 1'b0;
    while (tracker.expected_beats.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // apb write of the memory size, then a read back of the same register
  task automatic set_mem_words(logic [30:0] v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MemWordsAddr;
    pwdata  <= {1'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);  // register takes the value at this edge
    tracker.set_mem_words(v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[30:0] !== v)
      tracker.note_mismatch($sformatf("memory_words read back %h, wrote %h", rd[30:0], v));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [30:0] mem_setting;

    tracker = new();

    rst_ni                  = 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    instr_bus.valid         <= 1'b0;
    instr_bus.opcode        <= OP_NOP;
    instr_bus.dest_index    <= SlotNop;
    instr_bus.operand_kind  <= KindImm;
    instr_bus.operand       <= '0;
    instr_bus.bus_read_data <= '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed part, memory size left at its reset value
    // wrap on add, min / -1, divide by zero, truncation toward zero
    send_instr(mk(OP_MOV, SlotA, KindImm, 32'sh7FFFFFFF, 0));
    send_instr(mk(OP_ADD, SlotA, KindImm, 1, 0));
    send_instr(mk(OP_MOV, SlotB, KindImm, -1, 0));
    send_instr(mk(OP_DIV, SlotA, KindReg, 32'(SlotB), 0));
    send_instr(mk(OP_DIV, SlotC, KindImm, 0, 0));
    send_instr(mk(OP_MOV, SlotC, KindImm, 20, 0));
    send_instr(mk(OP_MOV, SlotD, KindImm, -7, 0));
    send_instr(mk(OP_DIV, SlotC, KindReg, 32'(SlotD), 0));
    send_instr(mk(OP_MUL, SlotB, KindImm, 32'sh00010001, 0));
    // same slot as dest and source, scratch included; stray source indexes
    send_instr(mk(OP_MUL, SlotA, KindReg, 32'(SlotA), 0));
    send_instr(mk(OP_SUB, SlotHigh, KindImm, 5, 0));
    send_instr(mk(OP_ADD, SlotA, KindReg, -3, 0));
    send_instr(mk(OP_MOV, SlotB, KindReg, 11, 0));
    send_instr(mk(OP_ADD, SlotC, KindKeepLo, 32'sh55555555, 0));
    // compare and every conditional jump, some taken and some not
    send_instr(mk(OP_CMP, SlotD, KindImm, -7, 0));
    send_instr(mk(OP_JE,  SlotNop, KindImm, 40, 0));
    send_instr(mk(OP_JL,  SlotNop, KindImm, 80, 0));
    send_instr(mk(OP_CMP, SlotD, KindImm, 0, 0));
    send_instr(mk(OP_JL,  SlotNop, KindImm, 120, 0));
    send_instr(mk(OP_JG,  SlotNop, KindImm, 8, 0));
    send_instr(mk(OP_JLE, SlotNop, KindImm, 200, 0));
    send_instr(mk(OP_JGE, SlotNop, KindImm, 16, 0));
    // counter near the top, the wrap on +4 and a jump to a negative target
    send_instr(mk(OP_JMP, SlotNop, KindImm, 32'sh7FFFFFFC, 0));
    send_instr(mk(OP_NOP, SlotNop, KindKeepHi, 0, 0));
    send_instr(mk(OP_JMP, SlotE, KindImm, -4, 0));
    // unknown opcode and divide by zero both aimed at e
    send_instr(mk(OpUnknown, SlotE, KindImm, 0, 0));
    send_instr(mk(OP_DIV, SlotE, KindImm, 0, 0));
    // bus read twice into iod, then an out with the io words set up
    send_instr(mk(OP_IN,  SlotIod, KindImm, 0, 32'shDEADBEEF));
    send_instr(mk(OP_IN,  SlotIod, KindReg, 32'(SlotC), 32'sh80000000));
    send_instr(mk(OP_MOV, SlotIob, KindImm, 32'sh7FFFFFFF, 0));
    send_instr(mk(OP_MOV, SlotIoc, KindReg, 32'(SlotIod), 0));
    send_instr(mk(OP_OUT, SlotA, KindKeepLo, 0, 0));

    // random phases, each under its own memory size; extremes included
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       mem_setting = 31'd0;
        1:       mem_setting = 31'h7FFFFFFF;
        2:       mem_setting = 31'd64;
        3:       mem_setting = 31'($urandom_range(1, 4096));
        4:       mem_setting = MemWordsReset;
        default: mem_setting = 31'($urandom());
      endcase
      drain(CfgSettle);
      set_mem_words(mem_setting);
      calm = (p == 2);
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        // halfway through, let the block run completely dry
        if (i == ItemsPerPhase / 2) drain(1);
        send_instr(rand_instr());
      end
    end
    calm = 1'b0;

    drain(EndSettle);
    if (tracker.expected_beats.size() != 0)
      tracker.note_mismatch("result beats still outstanding at the end");
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
